@@ src/flow_sensor_phase_corrected_conversion_core_assert.svh @@
// Assertion shorthands used by the block's top module.
// Each expects clk_i and rst_ni in the including scope.
`ifndef FLOW_SENSOR_PHASE_CORRECTED_CONVERSION_CORE_ASSERT_SVH
`define FLOW_SENSOR_PHASE_CORRECTED_CONVERSION_CORE_ASSERT_SVH

// Same-cycle implication.
`define FSPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fspc_pkg.sv @@
package fspc_pkg;

  // Payload of one sample and of one result.
  typedef struct packed {
    logic [15:0] raw_count;
    logic [1:0]  breath_phase;
  } fspc_in_t;

  typedef struct packed {
    logic signed [19:0] flow_uncorrected;
    logic signed [19:0] flow_corrected;
  } fspc_res_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_ENABLE = 2'd2
  } fspc_cfg_e;

  localparam int CFG_DATA_W = 24;
  localparam logic [15:0] OFFSET_RST = 16'd32768;
  localparam logic [23:0] GAIN_RST   = 24'd559241;

  // Breathing phase codes; anything else gets no correction.
  typedef enum logic [1:0] {
    PH_INSP = 2'd0,
    PH_EXP  = 2'd1,
    PH_NONE = 2'd2
  } fspc_phase_e;

  // How the correction fraction is formed.
  typedef enum logic [1:0] {
    FK_ZERO,
    FK_DIV,
    FK_CAP
  } fspc_kind_e;

  // All divided fraction segments share the denominator FRAC_DIV * 2^F.
  localparam int KNEE_FLOW   = 30;
  localparam int INSP_MUL    = 5500;
  localparam int EXP_LO_BASE = 118800;
  localparam int EXP_LO_MUL  = 2552;
  localparam int EXP_HI_BASE = 46200;
  localparam int EXP_HI_MUL  = 132;
  localparam int FRAC_DIV    = 6600000;
  localparam int FRAC_DIV_W  = 23;
  localparam int FRAC_CAP    = 26214;

  localparam int FLOW_W = 20;
  localparam int FRAC_W = 21;

  // Register stages from transfer to result strobe.
  localparam int PIPE_DEPTH = 10;

  // Scaled flow, handed from the scaler to the fraction unit.
  typedef struct packed {
    logic               valid;
    logic [1:0]         phase;
    logic signed [19:0] flow;
    logic [19:0]        mag;
  } fspc_flow_t;

  // Side data that rides along the divider stages.
  typedef struct packed {
    fspc_kind_e         kind;
    logic               neg;
    logic signed [19:0] flow;
  } fspc_tag_t;

  // Flow plus its correction fraction, handed to the output stages.
  typedef struct packed {
    logic               valid;
    logic signed [19:0] flow;
    logic signed [20:0] frac;
  } fspc_corr_t;

endpackage

@@ src/fspc_scale.sv @@
module fspc_scale #(
  parameter int FLOW_FRAC_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  fspc_pkg::fspc_in_t   in_i,
  input  logic [15:0]          offset_i,
  input  logic [23:0]          gain_i,
  output fspc_pkg::fspc_flow_t out_o
);

  localparam int SH = 26 - FLOW_FRAC_BITS;

  // Stage 1: offset removal.
  logic signed [16:0] diff;
  logic [15:0]        mag_d, mag_q;
  logic               pos_d, pos1_q;
  logic [1:0]         ph1_q;

  // Stage 2: gain multiply.
  logic [39:0]        prod_d, prod_q;
  logic               pos2_q;
  logic [1:0]         ph2_q;

  // Stage 3: shift, negate, saturate.
  logic [39:0]        shr;
  logic signed [19:0] flow_d, flow_q;
  logic [19:0]        amag_d, amag_q;
  logic [1:0]         ph3_q;

  logic [2:0]         v_q;

  always_comb begin
    diff  = $signed({1'b0, in_i.raw_count}) - $signed({1'b0, offset_i});
    mag_d = diff[16] ? 16'(-diff) : diff[15:0];
    pos_d = !diff[16] && (diff != '0);
  end

  assign prod_d = 40'(mag_q) * 40'(gain_i);

  always_comb begin
    shr = prod_q >> SH;
    if (pos2_q) begin
      if (shr > 40'd524288) begin
        flow_d = 20'sh80000;
        amag_d = 20'h80000;
      end else begin
        flow_d = -$signed(shr[19:0]);
        amag_d = shr[19:0];
      end
    end else begin
      if (shr > 40'd524287) begin
        flow_d = 20'sh7FFFF;
        amag_d = 20'h7FFFF;
      end else begin
        flow_d = $signed(shr[19:0]);
        amag_d = shr[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    pos1_q <= pos_d;
    ph1_q  <= in_i.breath_phase;
    prod_q <= prod_d;
    pos2_q <= pos1_q;
    ph2_q  <= ph1_q;
    flow_q <= flow_d;
    amag_q <= amag_d;
    ph3_q  <= ph2_q;
  end

  assign out_o.valid = v_q[2];
  assign out_o.phase = ph3_q;
  assign out_o.flow  = flow_q;
  assign out_o.mag   = amag_q;

endmodule

@@ src/fspc_frac.sv @@
module fspc_frac #(
  parameter int FLOW_FRAC_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fspc_pkg::fspc_flow_t in_i,
  output fspc_pkg::fspc_corr_t out_o
);

  localparam int P  = 20 - FLOW_FRAC_BITS;
  localparam int XW = (47 - FLOW_FRAC_BITS > 38) ? 47 - FLOW_FRAC_BITS : 38;
  localparam int MW = XW - 22;
  localparam int LW = 22;
  localparam int HW = XW - LW;
  localparam int NW = 36;
  localparam int DW = fspc_pkg::FRAC_DIV_W;

  localparam logic signed [NW-1:0] KNEE =
    NW'(longint'(fspc_pkg::KNEE_FLOW) << FLOW_FRAC_BITS);
  localparam logic signed [NW-1:0] K_EXP_LO =
    NW'(longint'(fspc_pkg::EXP_LO_BASE) << FLOW_FRAC_BITS);
  localparam logic signed [NW-1:0] K_EXP_HI =
    NW'(longint'(fspc_pkg::EXP_HI_BASE) << FLOW_FRAC_BITS);
  localparam logic signed [NW-1:0] M_INSP   = NW'(fspc_pkg::INSP_MUL);
  localparam logic signed [NW-1:0] M_EXP_LO = NW'(fspc_pkg::EXP_LO_MUL);
  localparam logic signed [NW-1:0] M_EXP_HI = NW'(fspc_pkg::EXP_HI_MUL);

  localparam logic [DW-1:0] DIVC  = DW'(fspc_pkg::FRAC_DIV);
  localparam logic [MW-1:0] RECIP = MW'((longint'(1) << XW) / fspc_pkg::FRAC_DIV);
  localparam logic signed [fspc_pkg::FRAC_W-1:0] CAP = fspc_pkg::FRAC_W'(fspc_pkg::FRAC_CAP);

  // Stage 4: pick the segment and build the numerator magnitude.
  logic signed [NW-1:0] a_s, n_s, nmag_s;
  fspc_pkg::fspc_tag_t  tag_d;
  logic [XW-1:0]        x_d;

  // Stages 4..7 carry tag and numerator.
  fspc_pkg::fspc_tag_t  tag_q [4];
  logic [XW-1:0]        x_q [4];
  logic [4:0]           v_q;

  // Stage 5: reciprocal partial products.
  logic [LW+MW-1:0]     plo_d, plo_q;
  logic [HW+MW-1:0]     phi_d, phi_q;

  // Stage 6: quotient estimate.
  logic [XW+MW-1:0]     sum;
  logic [MW-1:0]        qe_d, qe6_q, qe7_q;

  // Stage 7: back-multiply.
  logic [XW:0]          qd_d, qd_q;

  // Stage 8: one-step correction and sign.
  logic [XW:0]          rem;
  logic [MW-1:0]        qfix;
  logic [fspc_pkg::FRAC_W-1:0] qtr;
  logic signed [fspc_pkg::FRAC_W-1:0] frac_d, frac_q;

  always_comb begin
    a_s        = NW'(in_i.mag);
    n_s        = '0;
    tag_d.kind = fspc_pkg::FK_ZERO;
    tag_d.flow = in_i.flow;
    case (in_i.phase)
      fspc_pkg::PH_INSP: begin
        if (a_s <= KNEE) begin
          n_s        = a_s * M_INSP;
          tag_d.kind = fspc_pkg::FK_DIV;
        end else begin
          tag_d.kind = fspc_pkg::FK_CAP;
        end
      end
      fspc_pkg::PH_EXP: begin
        tag_d.kind = fspc_pkg::FK_DIV;
        if (a_s <= KNEE) begin
          n_s = K_EXP_LO - a_s * M_EXP_LO;
        end else begin
          n_s = K_EXP_HI - a_s * M_EXP_HI;
        end
      end
      default: begin
        tag_d.kind = fspc_pkg::FK_ZERO;
      end
    endcase
    tag_d.neg = n_s[NW-1];
    nmag_s    = n_s[NW-1] ? -n_s : n_s;
    x_d       = XW'(nmag_s) << P;
  end

  assign plo_d = (LW+MW)'(x_q[0][LW-1:0]) * (LW+MW)'(RECIP);
  assign phi_d = (HW+MW)'(x_q[0][XW-1:LW]) * (HW+MW)'(RECIP);

  always_comb begin
    sum  = {phi_q, LW'(0)} + (XW+MW)'(plo_q);
    qe_d = sum[XW+MW-1:XW];
  end

  assign qd_d = (XW+1)'(qe6_q) * (XW+1)'(DIVC);

  always_comb begin
    rem  = (XW+1)'(x_q[3]) - qd_q;
    qfix = (rem >= (XW+1)'(DIVC)) ? qe7_q + MW'(1) : qe7_q;
    qtr  = fspc_pkg::FRAC_W'(qfix);
    case (tag_q[3].kind)
      fspc_pkg::FK_DIV: frac_d = tag_q[3].neg ? -$signed(qtr) : $signed(qtr);
      fspc_pkg::FK_CAP: frac_d = CAP;
      default:          frac_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_d;
    x_q[0]   <= x_d;
    for (int i = 1; i < 4; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
    for (int i = 1; i < 4; i++) begin
      x_q[i] <= x_q[i-1];
    end
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    qe6_q  <= qe_d;
    qe7_q  <= qe6_q;
    qd_q   <= qd_d;
    frac_q <= frac_d;
  end

  // Stage 8 output register holds the flow seen at stage 7.
  logic signed [19:0] flow8_q;
  always_ff @(posedge clk_i) begin
    flow8_q <= tag_q[3].flow;
  end

  assign out_o.valid = v_q[4];
  assign out_o.flow  = flow8_q;
  assign out_o.frac  = frac_q;

endmodule

@@ src/fspc_apply.sv @@
module fspc_apply (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fspc_pkg::fspc_corr_t in_i,
  input  logic                 enable_i,
  output logic                 valid_o,
  output fspc_pkg::fspc_res_t  res_o
);

  localparam logic signed [22:0] ONE   = 23'sd1048576;
  localparam logic signed [42:0] ROUND = 43'sd1048575;

  // Stage 9: scale by one minus the fraction.
  logic signed [22:0] factor;
  logic signed [42:0] prod_d, prod_q;
  logic signed [19:0] flow9_q;

  // Stage 10: truncate toward zero, saturate, select.
  logic signed [42:0] adj;
  logic signed [22:0] shq;
  logic signed [19:0] corr;
  fspc_pkg::fspc_res_t res_d, res_q;
  logic [1:0]         v_q;

  always_comb begin
    factor = ONE - 23'(in_i.frac);
    prod_d = in_i.flow * factor;
  end

  always_comb begin
    adj = prod_q + (prod_q[42] ? ROUND : 43'sd0);
    shq = 23'(adj >>> 20);
    if (shq > 23'sd524287) begin
      corr = 20'sh7FFFF;
    end else if (shq < -23'sd524288) begin
      corr = 20'sh80000;
    end else begin
      corr = shq[19:0];
    end
    res_d.flow_uncorrected = flow9_q;
    res_d.flow_corrected   = enable_i ? corr : flow9_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    flow9_q <= in_i.flow;
    res_q   <= res_d;
  end

  assign valid_o = v_q[1];
  assign res_o   = res_q;

endmodule

@@ src/flow_sensor_phase_corrected_conversion_core.sv @@
// Channel  Handshake             Payload
// -------  --------------------  --------------------------------------------
// sample   start_i / busy_o      in_i: raw_count, breath_phase
// config   cfg_we_i              cfg_idx_i, cfg_wdata_i (offset, gain, enable)
// result   done_o (strobe)       res_o: flow_uncorrected, flow_corrected
//
// One sample per cycle while busy_o is low; each result follows its transfer through
// the scale, fraction and apply stages. The pipeline holds the constant divider for the
// correction fraction (reciprocal multiply, quotient, back-multiply, fix-up) and the gain multiply.
// busy_o is high during reset and in the first cycle after reset release.
// done_o is a one-cycle strobe; results are not held.

`include "flow_sensor_phase_corrected_conversion_core_assert.svh"

module flow_sensor_phase_corrected_conversion_core #(
  parameter int FLOW_FRAC_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  fspc_pkg::fspc_in_t                    in_i,
  input  logic                                  cfg_we_i,
  input  logic [fspc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fspc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output logic                                  done_o,
  output fspc_pkg::fspc_res_t                   res_o
);

  logic [15:0] offset_q;
  logic [23:0] gain_q;
  logic        cfg_en_q;
  logic        busy_q;
  logic        accept;

  fspc_pkg::fspc_flow_t flow_s;
  fspc_pkg::fspc_corr_t corr_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= fspc_pkg::OFFSET_RST;
      gain_q   <= fspc_pkg::GAIN_RST;
      cfg_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (fspc_pkg::fspc_cfg_e'(cfg_idx_i))
        fspc_pkg::CFG_OFFSET: offset_q <= cfg_wdata_i[15:0];
        fspc_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i[23:0];
        fspc_pkg::CFG_ENABLE: cfg_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Hold off the first cycle after reset release.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  fspc_scale #(
    .FLOW_FRAC_BITS(FLOW_FRAC_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_i       (in_i),
    .offset_i   (offset_q),
    .gain_i     (gain_q),
    .out_o      (flow_s)
  );

  fspc_frac #(
    .FLOW_FRAC_BITS(FLOW_FRAC_BITS)
  ) u_frac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (flow_s),
    .out_o  (corr_s)
  );

  fspc_apply u_apply (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (corr_s),
    .enable_i (cfg_en_q),
    .valid_o  (done_o),
    .res_o    (res_o)
  );

  `FSPC_ASSERT_IMP(a_done_has_transfer, done_o, $past(accept, fspc_pkg::PIPE_DEPTH), "result strobe without a transfer")
  `FSPC_ASSERT_IMP(a_transfer_gives_done, accept, ##(fspc_pkg::PIPE_DEPTH) done_o, "transfer without a result")
  `FSPC_ASSERT_IMP(a_bypass_match, done_o && !cfg_en_q, res_o.flow_corrected == res_o.flow_uncorrected, "bypass result differs")
  `FSPC_ASSERT_IMP(a_sign_kept, done_o, !(res_o.flow_uncorrected > 0 && res_o.flow_corrected < 0) && !(res_o.flow_uncorrected < 0 && res_o.flow_corrected > 0), "correction flipped the sign")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int          FLOW_FRAC   = 10;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  localparam logic [1:0]  PH_UNUSED      = 2'd3;
  localparam logic [1:0]  CFG_IDX_UNUSED = 2'd3;
  localparam logic [23:0] GAIN_MAX       = 24'hFFFFFF;
  localparam logic [23:0] GAIN_DOUBLE    = 24'd1118482;
  localparam longint      FRAC_ONE       = longint'(1) << 20;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start_i;
  logic                                busy_o;
  fspc_pkg::fspc_in_t                  in_i;
  logic                                cfg_we_i;
  logic [fspc_pkg::CFG_IDX_W-1:0]      cfg_idx_i;
  logic [fspc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i;
  logic                                done_o;
  fspc_pkg::fspc_res_t                 res_o;

  flow_sensor_phase_corrected_conversion_core #(
    .FLOW_FRAC_BITS(FLOW_FRAC)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Calibration as the block should hold it.
  logic [15:0] cal_offset;
  logic [23:0] cal_gain;
  logic        cal_corr_en;

  fspc_pkg::fspc_res_t flow_expect_q[$];
  int unsigned         mismatch_cnt;
  int unsigned         cycle_cnt;

  typedef struct {
    logic [15:0]        off;
    logic [23:0]        gain;
    logic               en;
    logic [15:0]        raw;
    logic [1:0]         ph;
    logic               known;
    logic signed [19:0] unc;
    logic signed [19:0] cor;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd32768, fspc_pkg::PH_INSP,
      1'b1, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd32768, fspc_pkg::PH_EXP,
      1'b1, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd0, fspc_pkg::PH_NONE,
      1'b1, 279620, 279620},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd65535, PH_UNUSED,
      1'b1, -279611, -279611},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd0, fspc_pkg::PH_INSP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd65535, fspc_pkg::PH_EXP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd29168, fspc_pkg::PH_INSP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd29167, fspc_pkg::PH_EXP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd32888, fspc_pkg::PH_EXP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd32767, fspc_pkg::PH_INSP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 16'd28768, PH_UNUSED,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b0, 16'd0, fspc_pkg::PH_INSP,
      1'b1, 279620, 279620},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b0, 16'd65535, fspc_pkg::PH_EXP,
      1'b1, -279611, -279611},
    '{fspc_pkg::OFFSET_RST, 24'd0, 1'b1, 16'd0, fspc_pkg::PH_INSP,
      1'b1, 0, 0},
    '{fspc_pkg::OFFSET_RST, 24'd0, 1'b1, 16'd65535, fspc_pkg::PH_EXP,
      1'b1, 0, 0},
    '{16'd0, GAIN_MAX, 1'b1, 16'd65535, fspc_pkg::PH_EXP,
      1'b1, -524288, -524288},
    '{16'd0, GAIN_MAX, 1'b1, 16'd65535, fspc_pkg::PH_INSP,
      1'b1, -524288, -511181},
    '{16'd0, GAIN_MAX, 1'b1, 16'd0, fspc_pkg::PH_INSP,
      1'b1, 0, 0},
    '{16'd65535, GAIN_MAX, 1'b1, 16'd0, fspc_pkg::PH_NONE,
      1'b1, 524287, 524287},
    '{16'd65535, GAIN_MAX, 1'b1, 16'd0, fspc_pkg::PH_EXP,
      1'b1, 524287, 524287},
    '{16'd0, 24'd1, 1'b1, 16'd65535, fspc_pkg::PH_EXP,
      1'b1, 0, 0},
    '{16'd0, 24'd65536, 1'b1, 16'd500, fspc_pkg::PH_EXP,
      1'b0, 0, 0},
    '{fspc_pkg::OFFSET_RST, GAIN_DOUBLE, 1'b1, 16'd10768, fspc_pkg::PH_EXP,
      1'b0, 0, 0}
  };

  typedef struct {
    logic [15:0] off;
    logic [23:0] gain;
    logic        en;
    logic        rnd_cal;
    int          idle_pct;
    int          count;
  } run_phase_t;

  localparam int RUN_PHASES = 9;
  run_phase_t run_phases [RUN_PHASES] = '{
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 1'b0, 0,  400},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 1'b0, 63, 350},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 1'b1, 15, 250},
    '{16'd0,                GAIN_MAX,           1'b1, 1'b0, 0,  150},
    '{16'd65535,            24'd1,              1'b0, 1'b0, 63, 100},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b0, 1'b1, 15, 200},
    '{fspc_pkg::OFFSET_RST, GAIN_DOUBLE,        1'b1, 1'b0, 63, 300},
    '{fspc_pkg::OFFSET_RST, 24'd0,              1'b1, 1'b0, 0,  50},
    '{fspc_pkg::OFFSET_RST, fspc_pkg::GAIN_RST, 1'b1, 1'b0, 15, 177}
  };

  function automatic longint clip_flow(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // Correction fraction in units of 2^-20, from the absolute flow.
  function automatic longint corr_fraction(input longint a, input logic [1:0] ph);
    longint s;
    longint knee;
    s    = longint'(1) << FLOW_FRAC;
    knee = 30 * s;
    case (ph)
      fspc_pkg::PH_INSP: begin
        if (a <= knee) return (a * FRAC_ONE) / (1200 * s);
        return 26214;
      end
      fspc_pkg::PH_EXP: begin
        if (a <= knee) return ((5400 * s - 116 * a) * FRAC_ONE) / (300000 * s);
        return ((14080 * s - 44 * (a - knee)) * FRAC_ONE) / (2200000 * s);
      end
      default: return 0;
    endcase
  endfunction

  function automatic fspc_pkg::fspc_res_t convert_flow(input fspc_pkg::fspc_in_t s);
    fspc_pkg::fspc_res_t r;
    longint    raw;
    longint    d;
    longint    mag;
    longint    scaled;
    longint    flow;
    longint    corr;
    longint    a;
    longint    gain;
    raw    = s.raw_count;
    gain   = cal_gain;
    d      = raw - longint'(cal_offset);
    mag    = (d < 0) ? -d : d;
    scaled = (mag * gain) >> (26 - FLOW_FRAC);
    flow   = clip_flow((d > 0) ? -scaled : scaled);
    corr   = flow;
    if (cal_corr_en) begin
      a    = (flow < 0) ? -flow : flow;
      corr = clip_flow((flow * (FRAC_ONE - corr_fraction(a, s.breath_phase))) / FRAC_ONE);
    end
    r.flow_uncorrected = flow[19:0];
    r.flow_corrected   = corr[19:0];
    return r;
  endfunction

  // Mostly samples around the calibrated zero, spread over both sides of the knee.
  function automatic fspc_pkg::fspc_in_t rand_sample();
    fspc_pkg::fspc_in_t s;
    longint   knee_cnt;
    longint   delta;
    longint   raw;
    int       sel;
    int       p;
    if (cal_gain == 0) knee_cnt = 4000;
    else knee_cnt = (30 * (longint'(1) << 26)) / longint'(cal_gain);
    if (knee_cnt > 30000) knee_cnt = 30000;
    if (knee_cnt < 3) knee_cnt = 3;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      raw = $urandom_range(0, 65535);
    end else begin
      if (sel < 85) delta = $urandom_range(0, 2 * knee_cnt);
      else delta = knee_cnt + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) delta = -delta;
      raw = longint'(cal_offset) + delta;
    end
    if (raw < 0) raw = 0;
    if (raw > 65535) raw = 65535;
    s.raw_count = raw[15:0];
    p = $urandom_range(0, 9);
    if (p < 4) s.breath_phase = fspc_pkg::PH_INSP;
    else if (p < 8) s.breath_phase = fspc_pkg::PH_EXP;
    else if (p == 8) s.breath_phase = fspc_pkg::PH_NONE;
    else s.breath_phase = PH_UNUSED;
    return s;
  endfunction

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      fspc_pkg::CFG_OFFSET: cal_offset  = data[15:0];
      fspc_pkg::CFG_GAIN:   cal_gain    = data;
      fspc_pkg::CFG_ENABLE: cal_corr_en = data[0];
      default: ;
    endcase
  endtask

  task automatic load_calibration(input logic [15:0] off, input logic [23:0] gain,
                                  input logic en);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_IDX_UNUSED, junk[23:0]);
    junk = $urandom();
    write_reg(fspc_pkg::CFG_OFFSET, {junk[7:0], off});
    write_reg(fspc_pkg::CFG_GAIN, gain);
    junk = $urandom();
    write_reg(fspc_pkg::CFG_ENABLE, {junk[22:0], en});
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (flow_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Hold the sample until the transfer, then record what it should give.
  task automatic send_sample(input fspc_pkg::fspc_in_t s, input fspc_pkg::fspc_res_t want);
    start_i <= 1'b1;
    in_i    <= s;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    flow_expect_q.push_back(want);
  endtask

  always @(posedge clk_i) begin : result_check
    fspc_pkg::fspc_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (flow_expect_q.size() == 0) begin
        $error("unexpected result: flow_uncorrected %0d, flow_corrected %0d",
               res_o.flow_uncorrected, res_o.flow_corrected);
        mismatch_cnt++;
      end else begin
        want = flow_expect_q.pop_front();
        if (res_o.flow_uncorrected !== want.flow_uncorrected) begin
          $error("flow_uncorrected: expected %0d, got %0d",
                 want.flow_uncorrected, res_o.flow_uncorrected);
          mismatch_cnt++;
        end
        if (res_o.flow_corrected !== want.flow_corrected) begin
          $error("flow_corrected: expected %0d, got %0d",
                 want.flow_corrected, res_o.flow_corrected);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("flow_sensor_phase_corrected_conversion_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    fspc_pkg::fspc_in_t  s;
    fspc_pkg::fspc_res_t want;
    run_phase_t          ph;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = fspc_pkg::CFG_OFFSET;
    cfg_wdata_i  = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    cal_offset   = fspc_pkg::OFFSET_RST;
    cal_gain     = fspc_pkg::GAIN_RST;
    cal_corr_en  = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].off != cal_offset || dir_rows[i].gain != cal_gain ||
          dir_rows[i].en != cal_corr_en) begin
        start_i <= 1'b0;
        drain_results();
        load_calibration(dir_rows[i].off, dir_rows[i].gain, dir_rows[i].en);
      end
      s.raw_count    = dir_rows[i].raw;
      s.breath_phase = dir_rows[i].ph;
      if (dir_rows[i].known) begin
        want.flow_uncorrected = dir_rows[i].unc;
        want.flow_corrected   = dir_rows[i].cor;
      end else begin
        want = convert_flow(s);
      end
      send_sample(s, want);
    end

    for (int p = 0; p < RUN_PHASES; p++) begin
      ph = run_phases[p];
      if (ph.rnd_cal) begin
        ph.off  = 16'($urandom_range(20000, 45000));
        ph.gain = 24'($urandom_range(1, 24'hFFFFFF));
      end
      start_i <= 1'b0;
      drain_results();
      load_calibration(ph.off, ph.gain, ph.en);
      for (int n = 0; n < ph.count; n++) begin
        // Hold off once mid-phase until the pipeline is empty.
        if (n == ph.count / 2 && ph.idle_pct != 0) begin
          start_i <= 1'b0;
          drain_results();
        end
        while ($urandom_range(0, 99) < ph.idle_pct) begin
          start_i <= 1'b0;
          @(posedge clk_i);
        end
        s = rand_sample();
        send_sample(s, convert_flow(s));
      end
    end

    start_i <= 1'b0;
    drain_results();
    repeat (2 * fspc_pkg::PIPE_DEPTH) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("flow_sensor_phase_corrected_conversion_core regression: pass");
    end else begin
      $display("flow_sensor_phase_corrected_conversion_core regression: fail");
    end
    $finish;
  end

endmodule
